[rtl/core/hbrke_pkg.sv]
// ----------------------------------------------------------------------------
// hbrke_pkg
// Types and constants shared by the boot-keyboard report event unit.
// ----------------------------------------------------------------------------
package hbrke_pkg;

  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MAX_SLOTS = 6;
  localparam int unsigned EVENTS    = MOD_BITS + 2 * MAX_SLOTS;
  localparam int unsigned EVT_IDX_W = $clog2(EVENTS);
  localparam int unsigned SLOT_IDX_W = $clog2(MAX_SLOTS);

  // Event mask layout: modifiers, then presses, then releases
  localparam int unsigned PRESS_BASE   = MOD_BITS;
  localparam int unsigned RELEASE_BASE = MOD_BITS + MAX_SLOTS;

  localparam logic [7:0] MOD_BASE_CODE = 8'hE0;
  localparam logic [7:0] MAX_ERR_CODE  = 8'd3;

  // Job queue between classifier and event sequencer
  localparam int unsigned JOB_DEPTH = 2;
  localparam int unsigned JOB_PTR_W = 1;
  localparam int unsigned JOB_CNT_W = 2;

  typedef struct packed {
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } report_t;

  typedef struct packed {
    logic       is_press;
    logic [7:0] usage_code;
    logic       last_event;
  } key_event_t;

  typedef struct packed {
    logic [EVENTS-1:0]             ev_mask;
    logic [7:0]                    cur_mod;
    logic [MAX_SLOTS-1:0][7:0]     cur_slots;
    logic [MAX_SLOTS-1:0][7:0]     prev_slots;
  } job_t;

endpackage

[rtl/core/hbrke_front.sv]
// ----------------------------------------------------------------------------
// hbrke_front
// Accepts reports, compares them with the kept report and builds a job with
// one mask bit per event to emit. Kept report updates on every accept.
// ----------------------------------------------------------------------------
module hbrke_front import hbrke_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  report_t report_i,
  output logic    job_push_o,
  output job_t    job_o,
  input  logic    job_full_i
);

  logic [7:0]                cur_mod;
  logic [MAX_SLOTS-1:0][7:0] cur;
  logic [7:0]                prev_mod_q, prev_mod_d;
  logic [MAX_SLOTS-1:0][7:0] prev_slots_q, prev_slots_d;
  logic [MAX_SLOTS-1:0]      press_mask, release_mask;
  logic                      accept;

  assign cur_mod = report_i.modifier_bits;
  assign cur[0]  = report_i.key_slot_0;
  assign cur[1]  = report_i.key_slot_1;
  assign cur[2]  = report_i.key_slot_2;
  assign cur[3]  = report_i.key_slot_3;
  assign cur[4]  = report_i.key_slot_4;
  assign cur[5]  = report_i.key_slot_5;

  assign full   = job_full_i;
  assign accept = push && !full;

  // Presence tests over the active slots
  always_comb begin
    logic in_prev, in_cur;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      in_prev = 1'b0;
      in_cur  = 1'b0;
      for (int j = 0; j < MAX_SLOTS; j++) begin
        if (j < KEY_SLOTS) begin
          in_prev = in_prev | (prev_slots_q[j] == cur[i]);
          in_cur  = in_cur  | (cur[j] == prev_slots_q[i]);
        end
      end
      press_mask[i]   = (i < KEY_SLOTS) && (cur[i] > MAX_ERR_CODE) && !in_prev;
      release_mask[i] = (i < KEY_SLOTS) && (prev_slots_q[i] > MAX_ERR_CODE) && !in_cur;
    end
  end

  // Job build
  always_comb begin
    job_o.ev_mask    = {release_mask, press_mask, prev_mod_q ^ cur_mod};
    job_o.cur_mod    = cur_mod;
    job_o.cur_slots  = cur;
    job_o.prev_slots = prev_slots_q;
    job_push_o       = accept && (|job_o.ev_mask);
  end

  // Kept report; inactive slots stay zero
  always_comb begin
    prev_mod_d   = prev_mod_q;
    prev_slots_d = prev_slots_q;
    if (accept) begin
      prev_mod_d = cur_mod;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (i < KEY_SLOTS) prev_slots_d[i] = cur[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mod_q   <= '0;
      prev_slots_q <= '0;
    end else begin
      prev_mod_q   <= prev_mod_d;
      prev_slots_q <= prev_slots_d;
    end
  end

  // The last slot, when unused, never holds a nonzero kept code
  a_unused_slots_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (KEY_SLOTS >= MAX_SLOTS) || (prev_slots_q[MAX_SLOTS-1] == '0))
    else $error("inactive key slot was written");

  // A report that changes nothing never reaches the queue
  a_empty_job_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> (job_o.ev_mask != '0))
    else $error("empty job pushed");

  // Accept never happens while the queue is full
  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> !job_full_i)
    else $error("job pushed into full queue");

endmodule

[rtl/core/hbrke_job_fifo.sv]
// ----------------------------------------------------------------------------
// hbrke_job_fifo
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module hbrke_job_fifo import hbrke_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o,
  input  logic pop_i
);

  job_t                 entries_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [JOB_CNT_W-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == JOB_CNT_W'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= job_i;
  end

endmodule

[rtl/core/hbrke_back.sv]
// ----------------------------------------------------------------------------
// hbrke_back
// Walks a job's event mask lowest bit first, one event per cycle, into an
// output register drained by empty/pop.
// ----------------------------------------------------------------------------
module hbrke_back import hbrke_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  output logic       empty,
  input  logic       pop,
  output key_event_t event_o
);

  logic [EVENTS-1:0]     mask_q, mask_d;
  job_t                  job_q;
  logic                  out_valid_q, out_valid_d;
  key_event_t            out_q, out_d;
  logic                  busy, load, emit;
  logic [EVENTS-1:0]     pick_oh, rest;
  logic [EVT_IDX_W-1:0]  idx;
  logic [SLOT_IDX_W-1:0] slot;
  key_event_t            evt;

  assign busy      = |mask_q;
  assign load      = !busy && job_valid_i;
  assign job_pop_o = load;
  assign emit      = busy && (!out_valid_q || pop);
  assign empty     = !out_valid_q;
  assign event_o   = out_q;

  // Lowest pending event
  assign pick_oh = mask_q & (~mask_q + 1'b1);
  assign rest    = mask_q & ~pick_oh;

  always_comb begin
    idx = '0;
    for (int k = 0; k < EVENTS; k++) begin
      if (pick_oh[k]) idx = EVT_IDX_W'(k);
    end
  end

  // Event decode by mask region
  always_comb begin
    slot           = '0;
    evt.last_event = (rest == '0);
    if (idx < EVT_IDX_W'(PRESS_BASE)) begin
      evt.is_press   = job_q.cur_mod[idx[2:0]];
      evt.usage_code = MOD_BASE_CODE | {5'b0, idx[2:0]};
    end else if (idx < EVT_IDX_W'(RELEASE_BASE)) begin
      slot           = SLOT_IDX_W'(idx - EVT_IDX_W'(PRESS_BASE));
      evt.is_press   = 1'b1;
      evt.usage_code = job_q.cur_slots[slot];
    end else begin
      slot           = SLOT_IDX_W'(idx - EVT_IDX_W'(RELEASE_BASE));
      evt.is_press   = 1'b0;
      evt.usage_code = job_q.prev_slots[slot];
    end
  end

  // Next state
  always_comb begin
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) mask_d = job_i.ev_mask;
    else if (emit) mask_d = rest;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = evt;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (load) job_q <= job_i;
  end

  // Only one event is picked per cycle
  a_pick_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> $onehot(pick_oh))
    else $error("event pick not one-hot");

  // Final event of a job leaves the sequencer idle
  a_last_idles : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && evt.last_event) |=> !busy)
    else $error("events left after last beat");

  // A loaded job always carries at least one event
  a_load_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy)
    else $error("loaded job had no events");

endmodule

[rtl/core/hid_boot_report_key_events_unit.sv]
// A report's first event passes the job queue, the sequencer's job register and
// the output register. Events leave one per cycle while the receiver pops; a
// job of up to 20 events is loaded into the sequencer before its first event.
// A two-entry job queue lets reports be taken while earlier events drain.
// Reset: asynchronous active low; kept report cleared to zero, queues empty.
// ----------------------------------------------------------------------------
// hid_boot_report_key_events_unit
// Turns boot-keyboard reports into ordered key press/release beats.
// ----------------------------------------------------------------------------
module hid_boot_report_key_events_unit import hbrke_pkg::*; #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  report_t    report_i,
  output logic       empty,
  input  logic       pop,
  output key_event_t event_o
);

  logic job_push, job_full, job_valid, job_pop;
  job_t job_in, job_out;

  // Classifier
  hbrke_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .report_i   (report_i),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  // Job queue
  hbrke_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .valid_o (job_valid),
    .job_o   (job_out),
    .pop_i   (job_pop)
  );

  // Event sequencer
  hbrke_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .empty       (empty),
    .pop         (pop),
    .event_o     (event_o)
  );

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the boot-keyboard report event unit.
// A directed table walks modifier and key extremes, error codes, duplicates
// and unchanged reports. A random keyboard session follows. Every event beat
// is checked against a typed expectation or a local model of the report
// differ, under bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench import hbrke_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SLOTS   = 6;
  localparam int          RAND_ITEMS  = 186;
  localparam int          USE_MODEL   = -1;   // row expectation comes from the model
  localparam int          HOLD_CYCLES = 300;
  localparam int          PAUSE_AT    = 130;  // random item index of the full drain
  localparam int          TAIL_CYCLES = 40;

  typedef logic [MAX_SLOTS-1:0][7:0] key_list_t;

  typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_e;

  typedef struct {
    report_t    rpt;
    int         n_typed;
    key_event_t typed [2];
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  report_t    report_i;
  logic       empty;
  logic       pop;
  key_event_t event_o;

  // Model state: kept report, cleared like the block at reset
  logic [7:0] held_mods = '0;
  key_list_t  held_keys = '0;

  key_event_t fresh_events [$];
  key_event_t pending_events [$];
  stim_row_t  stim_rows [$];

  int    cur_row = USE_MODEL;
  int    reports_taken = 0;
  int    events_seen = 0;
  int    mismatches = 0;
  int    input_stalls = 0;
  int    n_directed = 0;
  logic  hold_rx = 1'b0;
  report_t last_report = '0;

  hid_boot_report_key_events_unit #(
    .KEY_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .report_i(report_i),
    .empty   (empty),
    .pop     (pop),
    .event_o (event_o)
  );

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic key_list_t keys_of(input report_t r);
    key_list_t k;
    k[0] = r.key_slot_0;
    k[1] = r.key_slot_1;
    k[2] = r.key_slot_2;
    k[3] = r.key_slot_3;
    k[4] = r.key_slot_4;
    k[5] = r.key_slot_5;
    return k;
  endfunction

  function automatic report_t make_report(input logic [7:0] m, input key_list_t k);
    report_t r;
    r.modifier_bits = m;
    r.key_slot_0 = k[0];
    r.key_slot_1 = k[1];
    r.key_slot_2 = k[2];
    r.key_slot_3 = k[3];
    r.key_slot_4 = k[4];
    r.key_slot_5 = k[5];
    return r;
  endfunction

  function automatic key_event_t make_event(input logic p, input logic [7:0] code,
                                            input logic last);
    key_event_t e;
    e.is_press   = p;
    e.usage_code = code;
    e.last_event = last;
    return e;
  endfunction

  function automatic bit key_held(input key_list_t keys, input logic [7:0] code);
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (keys[s] == code) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Diff one report against the kept one; fills fresh_events, updates state
  function automatic void predict_events(input report_t rpt);
    key_list_t  now_keys;
    logic [7:0] mod_diff;
    now_keys = keys_of(rpt);
    mod_diff = held_mods ^ rpt.modifier_bits;
    fresh_events.delete();
    for (int b = 0; b < MOD_BITS; b++) begin
      if (mod_diff[b])
        fresh_events.push_back(make_event(rpt.modifier_bits[b], MOD_BASE_CODE + 8'(b), 1'b0));
    end
    // presses: new codes above the error range, slot order
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (now_keys[s] > MAX_ERR_CODE && !key_held(held_keys, now_keys[s]))
        fresh_events.push_back(make_event(1'b1, now_keys[s], 1'b0));
    end
    // releases: kept codes that are gone now
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (held_keys[s] > MAX_ERR_CODE && !key_held(now_keys, held_keys[s]))
        fresh_events.push_back(make_event(1'b0, held_keys[s], 1'b0));
    end
    if (fresh_events.size() > 0)
      fresh_events[fresh_events.size()-1].last_event = 1'b1;
    held_mods = rpt.modifier_bits;
    for (int s = 0; s < NUM_SLOTS; s++) held_keys[s] = now_keys[s];
  endfunction

  task automatic note_failure(input string what, input key_event_t want,
                              input key_event_t got);
    if (mismatches < 10)
      $display("[%0t] %s: expected press=%0b code=%02h last=%0b, got press=%0b code=%02h last=%0b",
               $realtime, what, want.is_press, want.usage_code, want.last_event,
               got.is_press, got.usage_code, got.last_event);
    mismatches++;
  endtask

  // Sample both handshakes at the rising edge; results first, then new reports
  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni) begin
      if (!empty && pop) begin
        events_seen++;
        if (pending_events.size() == 0) begin
          note_failure("unexpected event beat", '0, event_o);
        end else begin
          want = pending_events.pop_front();
          if (event_o.is_press !== want.is_press || event_o.usage_code !== want.usage_code ||
              event_o.last_event !== want.last_event)
            note_failure("event mismatch", want, event_o);
        end
      end
      if (push && full) input_stalls++;
      if (push && !full) begin
        predict_events(report_i);
        if (cur_row != USE_MODEL && stim_rows[cur_row].n_typed != USE_MODEL) begin
          for (int k = 0; k < stim_rows[cur_row].n_typed; k++)
            pending_events.push_back(stim_rows[cur_row].typed[k]);
        end else begin
          foreach (fresh_events[k]) pending_events.push_back(fresh_events[k]);
        end
        reports_taken++;
      end
    end
  end

  // Receiver: switches between stall patterns, or holds off entirely
  initial begin
    rx_mode_e mode;
    int       left;
    pop  = 1'b0;
    mode = RX_STREAM;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        left = $urandom_range(8, 64);
      end
      left--;
      if (hold_rx) begin
        pop <= 1'b0;
      end else begin
        case (mode)
          RX_STREAM: pop <= 1'b1;
          RX_HALF:   pop <= ($urandom_range(0, 1) == 0);
          default:   pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Long receiver hold-off early in the random session; input must fill up
  initial begin
    wait (n_directed > 0 && reports_taken >= n_directed + 40);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  function automatic logic [7:0] rand_key();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));    // empty slot or error code
      1, 2:    return 8'($urandom_range(4, 12));   // small pool, so codes recur
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Next report of a random keyboard session, with some noise mixed in
  function automatic report_t next_random_report(input report_t base);
    key_list_t  keys;
    logic [7:0] mods;
    logic [7:0] tmp;
    int         a;
    int         b;
    int         pick;
    keys = keys_of(base);
    mods = base.modifier_bits;
    pick = $urandom_range(0, 19);
    if (pick < 12) begin
      if ($urandom_range(0, 2) == 0) mods ^= 8'(1 << $urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) mods ^= 8'($urandom_range(0, 255));
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if ($urandom_range(0, 3) == 0) keys[s] = rand_key();
      end
      a = $urandom_range(0, NUM_SLOTS - 1);
      b = $urandom_range(0, NUM_SLOTS - 1);
      if ($urandom_range(0, 5) == 0) keys[a] = keys[b];       // duplicate code
      else if ($urandom_range(0, 5) == 0) begin                // reorder slots
        tmp = keys[a];
        keys[a] = keys[b];
        keys[b] = tmp;
      end
    end else if (pick < 14) begin
      // unchanged report
    end else if (pick < 16) begin
      tmp = 8'($urandom_range(1, 3));
      for (int s = 0; s < NUM_SLOTS; s++) keys[s] = tmp;      // rollover report
      if ($urandom_range(0, 1) == 0) mods = 8'($urandom_range(0, 255));
    end else begin
      mods = 8'($urandom_range(0, 255));
      for (int s = 0; s < NUM_SLOTS; s++) keys[s] = 8'($urandom_range(0, 255));
    end
    return make_report(mods, keys);
  endfunction

  task automatic add_row(input report_t rpt, input int n,
                         input key_event_t e0 = '0, input key_event_t e1 = '0);
    stim_row_t row;
    row.rpt      = rpt;
    row.n_typed  = n;
    row.typed[0] = e0;
    row.typed[1] = e1;
    stim_rows.push_back(row);
  endtask

  // Offer one report from a falling edge; return at the falling edge after the beat
  task automatic send_report(input report_t rpt, input int row);
    int taken_before;
    taken_before = reports_taken;
    report_i <= rpt;
    push     <= 1'b1;
    cur_row   = row;
    do @(negedge clk_i); while (reports_taken == taken_before);
    last_report = rpt;
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  task automatic pause_until_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (pending_events.size() != 0);
  endtask

  // Stimulus
  initial begin
    int burst_left;
    push     = 1'b0;
    report_i = '0;
    rst_ni   = 1'b0;

    // Directed rows: typed expectation where obvious, model otherwise
    add_row(make_report(8'h00, '0), 0);
    add_row(make_report(8'h01, '0), 1, make_event(1'b1, 8'hE0, 1'b1));
    add_row(make_report(8'h00, '0), 1, make_event(1'b0, 8'hE0, 1'b1));
    add_row(make_report(8'h80, '0), 1, make_event(1'b1, 8'hE7, 1'b1));
    add_row(make_report(8'hFF, '0), USE_MODEL);
    add_row(make_report(8'h00, '0), USE_MODEL);
    add_row(make_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04}), 1,
            make_event(1'b1, 8'h04, 1'b1));
    add_row(make_report(8'h00, '0), 1, make_event(1'b0, 8'h04, 1'b1));
    add_row(make_report(8'h00, {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}), 1,
            make_event(1'b1, 8'hFF, 1'b1));
    add_row(make_report(8'h00, {8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}), 0);
    add_row(make_report(8'h00, {6{8'h01}}), 1, make_event(1'b0, 8'hFF, 1'b1));
    add_row(make_report(8'h00, {6{8'h01}}), 0);
    add_row(make_report(8'h00, {8'h00, 8'h03, 8'h02, 8'h01, 8'h03, 8'h02}), 0);
    add_row(make_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h05}), 2,
            make_event(1'b1, 8'h05, 1'b0), make_event(1'b1, 8'h05, 1'b1));
    add_row(make_report(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05}), 0);
    add_row(make_report(8'h00, '0), 1, make_event(1'b0, 8'h05, 1'b1));
    add_row(make_report(8'h00, {8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04}), USE_MODEL);
    add_row(make_report(8'h00, {8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09}), 0);
    add_row(make_report(8'hFF, {8'h0F, 8'h0E, 8'h0D, 8'h0C, 8'h0B, 8'h0A}), USE_MODEL);
    add_row(make_report(8'hAA, {8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF}), USE_MODEL);
    add_row(make_report(8'h55, {8'hFD, 8'h01, 8'hFE, 8'h00, 8'hFF, 8'h00}), USE_MODEL);
    add_row(make_report(8'h00, '0), USE_MODEL);
    add_row(make_report(8'h01, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04}), 2,
            make_event(1'b1, 8'hE0, 1'b0), make_event(1'b1, 8'h04, 1'b1));
    add_row(make_report(8'h00, '0), 2,
            make_event(1'b0, 8'hE0, 1'b0), make_event(1'b0, 8'h04, 1'b1));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_rows[i]) begin
      send_report(stim_rows[i].rpt, i);
      sender_gap($urandom_range(0, 3));
    end
    pause_until_drained();
    n_directed = stim_rows.size();

    // Random keyboard session in bursts
    burst_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == PAUSE_AT) begin
        pause_until_drained();
      end else if (burst_left == 0) begin
        sender_gap($urandom_range(0, 15));
        burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      send_report(next_random_report(last_report), USE_MODEL);
    end
    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_events.size() != 0) begin
      $display("%0d expected event beats never arrived", pending_events.size());
      mismatches++;
    end
    $display("Sent %0d reports (%0d from the directed table), checked %0d event beats.",
             reports_taken, n_directed, events_seen);
    $display("Input was held back by a full block for %0d cycles; %0d failures seen.",
             input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("** hid_boot_report_key_events_unit: PASSED **");
    end else begin
      $display("** hid_boot_report_key_events_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Timeout: %0d reports taken, %0d beats still expected",
             reports_taken, pending_events.size());
    $display("** hid_boot_report_key_events_unit: FAILED **");
    $finish;
  end

endmodule
